FILE: hw/rtl/slist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slist_pkg
// Shared types for the sequential list engine: request and result payloads,
// operation and status codes, and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package slist_pkg;

  typedef enum logic [3:0] {
    FN_CREATE  = 4'd0,
    FN_DESTROY = 4'd1,
    FN_CLEAR   = 4'd2,
    FN_GET     = 4'd3,
    FN_LOCATE  = 4'd4,
    FN_PRIOR   = 4'd5,
    FN_NEXT    = 4'd6,
    FN_INSERT  = 4'd7,
    FN_DELETE  = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         func;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [7:0]         index_found;
    logic [7:0]         count;
    logic               is_empty;
  } out_t;

  typedef enum logic [2:0] {
    PTR_HOLD  = 3'd0,
    PTR_ZERO  = 3'd1,
    PTR_FILL  = 3'd2,
    PTR_POSM1 = 3'd3,
    PTR_INC   = 3'd4,
    PTR_DEC   = 3'd5
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_POSM1 = 2'd1,
    RD_PTR   = 2'd2,
    RD_PTRM1 = 2'd3
  } rd_op_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_DOWN = 2'd1,
    WR_UP   = 2'd2,
    WR_VAL  = 2'd3
  } wr_op_e;

  typedef enum logic [1:0] {
    FILL_HOLD = 2'd0,
    FILL_ZERO = 2'd1,
    FILL_INC  = 2'd2,
    FILL_DEC  = 2'd3
  } fill_op_e;

  typedef enum logic [1:0] {
    ELEM_HOLD  = 2'd0,
    ELEM_RDATA = 2'd1,
    ELEM_PREV  = 2'd2
  } elem_op_e;

  typedef struct packed {
    logic     load_req;
    ptr_op_e  ptr_op;
    rd_op_e   rd_op;
    wr_op_e   wr_op;
    fill_op_e fill_op;
    logic     set_present;
    logic     clr_present;
    logic     set_status;
    status_e  status;
    elem_op_e elem_op;
    logic     set_idx;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       present;
    logic       pos_rd_ok;
    logic       pos_ins_ok;
    logic       full;
    logic       ptr_lt_fill;
    logic       ptr_ge_pos;
    logic       rd_pend;
    logic       match;
    logic       last_is_first;
    logic       last_is_posm1;
    logic       next_in_range;
  } stat_t;

endpackage

FILE: hw/rtl/slist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slist_ctrl
// Sequencer for the list engine: decodes the captured request, steps the
// datapath through scans and shifts, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module slist_ctrl
  import slist_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_RDWAIT  = 8'b0000_0100,
    S_SCAN    = 8'b0000_1000,
    S_DEL     = 8'b0001_0000,
    S_INS     = 8'b0010_0000,
    S_INS_PUT = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.status = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_FIN;
        unique case (stat_i.func)
          FN_CREATE: begin
            cmd_o.set_present = 1'b1;
            cmd_o.fill_op     = FILL_ZERO;
          end
          FN_DESTROY, FN_CLEAR, FN_GET, FN_LOCATE, FN_PRIOR, FN_NEXT,
          FN_INSERT, FN_DELETE: begin
            if (!stat_i.present) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_ABSENT;
            end else if (stat_i.func == FN_DESTROY) begin
              cmd_o.clr_present = 1'b1;
              cmd_o.fill_op     = FILL_ZERO;
            end else if (stat_i.func == FN_CLEAR) begin
              cmd_o.fill_op = FILL_ZERO;
            end else if (stat_i.func == FN_LOCATE || stat_i.func == FN_PRIOR ||
                         stat_i.func == FN_NEXT) begin
              cmd_o.ptr_op = PTR_ZERO;
              state_d      = S_SCAN;
            end else if (stat_i.func == FN_INSERT) begin
              if (!stat_i.pos_ins_ok) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_BAD;
              end else if (stat_i.full) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_FULL;
              end else begin
                cmd_o.ptr_op = PTR_FILL;
                state_d      = S_INS;
              end
            end else if (!stat_i.pos_rd_ok) begin
              // get or delete with a position outside the list
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD;
            end else if (stat_i.func == FN_GET) begin
              cmd_o.rd_op = RD_POSM1;
              state_d     = S_RDWAIT;
            end else begin
              cmd_o.ptr_op = PTR_POSM1;
              state_d      = S_DEL;
            end
          end
          default: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_BAD;
          end
        endcase
      end

      S_RDWAIT: begin
        cmd_o.elem_op = ELEM_RDATA;
        state_d       = S_FIN;
      end

      S_SCAN: begin
        // one read issued per cycle, the compare lands in the next cycle
        if (stat_i.ptr_lt_fill) begin
          cmd_o.rd_op  = RD_PTR;
          cmd_o.ptr_op = PTR_INC;
        end
        if (stat_i.rd_pend && stat_i.match) begin
          state_d = S_FIN;
          unique case (stat_i.func)
            FN_LOCATE: cmd_o.set_idx = 1'b1;
            FN_PRIOR: begin
              if (stat_i.last_is_first) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_BAD;
              end else begin
                cmd_o.elem_op = ELEM_PREV;
              end
            end
            default: begin
              // the successor's read was issued in this same cycle
              if (!stat_i.next_in_range) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_BAD;
              end else begin
                state_d = S_RDWAIT;
              end
            end
          endcase
        end else if (!stat_i.rd_pend && !stat_i.ptr_lt_fill) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_BAD;
          state_d          = S_FIN;
        end
      end

      S_DEL: begin
        if (stat_i.ptr_lt_fill) begin
          cmd_o.rd_op  = RD_PTR;
          cmd_o.ptr_op = PTR_INC;
        end
        if (stat_i.rd_pend) begin
          if (stat_i.last_is_posm1) cmd_o.elem_op = ELEM_RDATA;
          else                      cmd_o.wr_op   = WR_DOWN;
        end else if (!stat_i.ptr_lt_fill) begin
          cmd_o.fill_op = FILL_DEC;
          state_d       = S_FIN;
        end
      end

      S_INS: begin
        if (stat_i.ptr_ge_pos) begin
          cmd_o.rd_op  = RD_PTRM1;
          cmd_o.ptr_op = PTR_DEC;
        end
        if (stat_i.rd_pend) begin
          cmd_o.wr_op = WR_UP;
        end else if (!stat_i.ptr_ge_pos) begin
          state_d = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        cmd_o.wr_op   = WR_VAL;
        cmd_o.fill_op = FILL_INC;
        state_d       = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/slist_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slist_dp
// Datapath for the list engine: request register, element memory with a
// registered read port, walk pointer, fill count and the result register.
// ----------------------------------------------------------------------------
module slist_dp
  import slist_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_data_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output out_t  out_data_o
);

  localparam int FW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = ((FW > 8) ? FW : 8) + 1;

  logic [31:0]   mem_q [CAPACITY];

  in_t           req_q;
  logic          present_q, present_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] last_ra_q;
  logic          rd_pend_q;
  logic [31:0]   rdata_q;
  logic [31:0]   prev_q;
  status_e       res_status_q;
  logic [31:0]   res_elem_q;
  logic [7:0]    res_idx_q;
  out_t          out_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  logic [CW-1:0] pos_x, fill_x, ptr_x, last_x;

  assign pos_x  = CW'(req_q.position);
  assign fill_x = CW'(fill_q);
  assign ptr_x  = CW'(ptr_q);
  assign last_x = CW'(last_ra_q);

  // status toward the controller
  always_comb begin
    stat_o.func          = req_q.func;
    stat_o.present       = present_q;
    stat_o.pos_rd_ok     = (pos_x != '0) && (pos_x <= fill_x);
    stat_o.pos_ins_ok    = (pos_x != '0) && (pos_x <= fill_x + CW'(1));
    stat_o.full          = (fill_x == CW'(CAPACITY));
    stat_o.ptr_lt_fill   = (ptr_q < fill_q);
    stat_o.ptr_ge_pos    = (ptr_x >= pos_x);
    stat_o.rd_pend       = rd_pend_q;
    stat_o.match         = (rdata_q == req_q.value);
    stat_o.last_is_first = (last_ra_q == '0);
    stat_o.last_is_posm1 = ((last_x + CW'(1)) == pos_x);
    stat_o.next_in_range = ((last_x + CW'(1)) < fill_x);
  end

  // memory port selection
  always_comb begin
    rd_en   = (cmd_i.rd_op != RD_NONE);
    rd_addr = AW'(ptr_q);
    case (cmd_i.rd_op)
      RD_POSM1: rd_addr = AW'(pos_x - CW'(1));
      RD_PTRM1: rd_addr = AW'(ptr_x - CW'(1));
      default:  rd_addr = AW'(ptr_q);
    endcase

    wr_en   = (cmd_i.wr_op != WR_NONE);
    wr_addr = last_ra_q;
    wr_data = rdata_q;
    case (cmd_i.wr_op)
      WR_DOWN: wr_addr = last_ra_q - AW'(1);
      WR_UP:   wr_addr = last_ra_q + AW'(1);
      WR_VAL: begin
        wr_addr = AW'(pos_x - CW'(1));
        wr_data = req_q.value;
      end
      default: wr_addr = last_ra_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      PTR_ZERO:  ptr_d = '0;
      PTR_FILL:  ptr_d = fill_q;
      PTR_POSM1: ptr_d = FW'(pos_x - CW'(1));
      PTR_INC:   ptr_d = ptr_q + FW'(1);
      PTR_DEC:   ptr_d = ptr_q - FW'(1);
      default:   ptr_d = ptr_q;
    endcase

    fill_d = fill_q;
    case (cmd_i.fill_op)
      FILL_ZERO: fill_d = '0;
      FILL_INC:  fill_d = fill_q + FW'(1);
      FILL_DEC:  fill_d = fill_q - FW'(1);
      default:   fill_d = fill_q;
    endcase

    present_d = present_q;
    if (cmd_i.set_present)      present_d = 1'b1;
    else if (cmd_i.clr_present) present_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      fill_q    <= '0;
      ptr_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      present_q <= present_d;
      fill_q    <= fill_d;
      ptr_q     <= ptr_d;
      rd_pend_q <= rd_en;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_data_i;
    if (rd_en) last_ra_q <= rd_addr;
    if (rd_pend_q) prev_q <= rdata_q;

    if (cmd_i.load_req) begin
      res_status_q <= ST_OK;
      res_elem_q   <= '0;
      res_idx_q    <= '0;
    end else begin
      if (cmd_i.set_status) res_status_q <= cmd_i.status;
      case (cmd_i.elem_op)
        ELEM_RDATA: res_elem_q <= rdata_q;
        ELEM_PREV:  res_elem_q <= prev_q;
        default:    res_elem_q <= res_elem_q;
      endcase
      if (cmd_i.set_idx) res_idx_q <= 8'(last_x + CW'(1));
    end

    if (cmd_i.out_load) begin
      out_q.status      <= res_status_q;
      out_q.element     <= res_elem_q;
      out_q.index_found <= res_idx_q;
      out_q.count       <= fill_x[7:0];
      out_q.is_empty    <= (fill_q == '0);
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Bounded list of signed 32-bit elements with create, destroy, clear, get,
// locate, prior, next, insert and delete requests; one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with in_data_i (func, position,
//   value); each transaction yields exactly one result on out_valid_o/
//   out_ready_i with out_data_o (status, element, index_found, count,
//   is_empty). One request is worked at a time.
//   Scans and shifts move one element per cycle through the element memory
//   (one read and one write port). With the receiver ready, the next
//   request is taken in the cycle after its predecessor's result loads.
//   If the receiver stalls, the finished result of the next request waits
//   in the engine until the output register drains.
//   Reset leaves the list absent with zero elements; memory is not cleared.
// ----------------------------------------------------------------------------
module sequential_list_engine
  import slist_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  slist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  slist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

FILE: sim/slist_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slist_checker
// Watches both channels of the list engine. Every accepted request runs
// through a shadow list, and the result it produces is queued. Every
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module slist_checker
  import slist_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o
);

  // shadow of the engine's list
  bit                 list_present;
  int unsigned        list_fill;
  logic signed [31:0] list_mem [CAPACITY];

  out_t owed_results[$];
  out_t due;

  function automatic int unsigned first_index_of(logic signed [31:0] v);
    int unsigned k;
    for (k = 0; k < list_fill; k++) begin
      if (list_mem[k] == v) return k;
    end
    return list_fill;
  endfunction

  // Applies one request to the shadow list and returns the result it gives.
  function automatic out_t list_op_result(in_t rq);
    out_t        r;
    int unsigned pos;
    int unsigned hit;
    int unsigned k;
    r   = '0;
    r.status = ST_OK;
    pos = rq.position;
    hit = first_index_of(rq.value);
    if (rq.func > FN_DELETE) begin
      r.status = ST_BAD;
    end else if (rq.func == FN_CREATE) begin
      list_present = 1'b1;
      list_fill    = 0;
    end else if (!list_present) begin
      r.status = ST_ABSENT;
    end else begin
      case (rq.func)
        FN_DESTROY: begin
          list_present = 1'b0;
          list_fill    = 0;
        end
        FN_CLEAR: list_fill = 0;
        FN_GET: begin
          if (pos < 1 || pos > list_fill) r.status = ST_BAD;
          else r.element = list_mem[pos-1];
        end
        FN_LOCATE: begin
          if (hit >= list_fill) r.status = ST_BAD;
          else r.index_found = 8'(hit + 1);
        end
        FN_PRIOR: begin
          if (hit >= list_fill || hit == 0) r.status = ST_BAD;
          else r.element = list_mem[hit-1];
        end
        FN_NEXT: begin
          if (hit + 1 >= list_fill) r.status = ST_BAD;
          else r.element = list_mem[hit+1];
        end
        FN_INSERT: begin
          // position is checked before the full condition
          if (pos < 1 || pos > list_fill + 1) begin
            r.status = ST_BAD;
          end else if (list_fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (k = list_fill; k > pos - 1; k--) list_mem[k] = list_mem[k-1];
            list_mem[pos-1] = rq.value;
            list_fill++;
          end
        end
        default: begin
          if (pos < 1 || pos > list_fill) begin
            r.status = ST_BAD;
          end else begin
            r.element = list_mem[pos-1];
            for (k = pos; k < list_fill; k++) list_mem[k-1] = list_mem[k];
            list_fill--;
          end
        end
      endcase
    end
    r.count    = 8'(list_fill);
    r.is_empty = (list_fill == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_present = 1'b0;
      list_fill    = 0;
      owed_results.delete();
      errors_o     = 0;
      pending_o   <= 0;
    end else begin
      // a result never belongs to the request taken on the same edge
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with no request outstanding (status %0d)",
                 out_data_i.status);
          errors_o++;
        end else begin
          due = owed_results.pop_front();
          check_field("status", 32'(due.status), 32'(out_data_i.status));
          check_field("element", due.element, out_data_i.element);
          check_field("index_found", 32'(due.index_found), 32'(out_data_i.index_found));
          check_field("count", 32'(due.count), 32'(out_data_i.count));
          check_field("is_empty", 32'(due.is_empty), 32'(out_data_i.is_empty));
        end
      end
      if (in_valid_i && in_ready_i) owed_results.push_back(list_op_result(in_data_i));
      pending_o <= owed_results.size();
    end
  end

endmodule

FILE: sim/tb_sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine
// Drives directed and random list requests into the engine in bursts while
// the result side stalls on shifting patterns; slist_checker predicts and
// compares every result. Ends with a verdict or on a stuck-channel timeout.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine;
  import slist_pkg::*;

  localparam int CAPACITY   = 128;
  localparam int ITEMS      = 1050;
  localparam int IDLE_LIMIT = 5000;

  // func codes the engine does not know
  localparam logic [3:0] FN_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] FN_UNKNOWN_HI = 4'd15;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int fail_count;
  int pending;

  // stimulus-side bookkeeping, used only to aim positions
  bit                 lst_live;
  int unsigned        lst_len;
  int                 sent;
  int                 burst_left;
  logic signed [31:0] value_pool [16];

  int stall_mode  = 0;
  int stall_left  = 0;
  int rx_cyc      = 0;
  int idle_cycles = 0;

  sequential_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  slist_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .errors_o   (fail_count),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_t req(logic [3:0] f, int pos, logic signed [31:0] v);
    in_t r;
    r.func     = f;
    r.position = 8'(pos);
    r.value    = v;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return value_pool[$urandom_range(0, 15)];
  endfunction

  // mostly in 1..hi, sometimes just past it or anywhere in the 8-bit range
  function automatic logic [7:0] pick_pos(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1 || hi == 0) return 8'(hi + 1);
    return 8'($urandom_range(1, hi));
  endfunction

  function automatic in_t next_req(int grow_pct, int shrink_pct);
    int x;
    int y;
    x = $urandom_range(0, 99);
    y = $urandom_range(0, 99);
    if (!lst_live) return req(FN_CREATE, $urandom_range(0, 255), $urandom);
    if (x < grow_pct) return req(FN_INSERT, pick_pos(lst_len + 1), pick_value());
    if (x < grow_pct + shrink_pct) return req(FN_DELETE, pick_pos(lst_len), $urandom);
    if (y < 25) return req(FN_GET, pick_pos(lst_len), $urandom);
    if (y < 50) return req(FN_LOCATE, $urandom_range(0, 255), pick_value());
    if (y < 72) return req(FN_PRIOR, $urandom_range(0, 255), pick_value());
    if (y < 98) return req(FN_NEXT, $urandom_range(0, 255), pick_value());
    return req(FN_CLEAR, $urandom_range(0, 255), $urandom);
  endfunction

  // Called right after a rising edge. Holds the request until accepted,
  // then either keeps valid up for the next one or opens a random gap.
  task automatic send(input in_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    case (it.func)
      FN_CREATE: begin
        lst_live = 1'b1;
        lst_len  = 0;
      end
      FN_DESTROY: begin
        lst_live = 1'b0;
        lst_len  = 0;
      end
      FN_CLEAR: lst_len = 0;
      FN_INSERT: begin
        if (lst_live && it.position >= 1 && it.position <= lst_len + 1 &&
            lst_len < CAPACITY) lst_len++;
      end
      FN_DELETE: begin
        if (lst_live && it.position >= 1 && it.position <= lst_len) lst_len--;
      end
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // hold off the request side until every outstanding result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result-side stalls: always ready, coin flip, sparse and periodic windows
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (rx_cyc % 8 == 0);
      default: out_ready_i <= (rx_cyc % 5 < 2);
    endcase
    rx_cyc++;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    lst_live    = 1'b0;
    lst_len     = 0;
    sent        = 0;
    burst_left  = 0;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: absent list, unknown codes, bad positions, extremes, neighbours
    send(req(FN_GET, 1, 0));
    send(req(FN_INSERT, 1, 5));
    send(req(FN_UNKNOWN_HI, 255, VAL_MAX));
    send(req(FN_CREATE, 0, 0));
    send(req(FN_GET, 1, 0));
    send(req(FN_DELETE, 0, 0));
    send(req(FN_INSERT, 0, 1));
    send(req(FN_INSERT, 2, 1));
    send(req(FN_INSERT, 1, VAL_MIN));
    send(req(FN_INSERT, 2, VAL_MAX));
    send(req(FN_INSERT, 1, -1));
    send(req(FN_INSERT, 2, 0));
    send(req(FN_GET, 4, 0));
    send(req(FN_GET, 5, 0));
    send(req(FN_LOCATE, 0, VAL_MIN));
    send(req(FN_LOCATE, 0, 12345));
    send(req(FN_PRIOR, 0, -1));
    send(req(FN_PRIOR, 0, VAL_MAX));
    send(req(FN_NEXT, 0, VAL_MAX));
    send(req(FN_NEXT, 0, -1));
    send(req(FN_DELETE, 1, 0));
    send(req(FN_UNKNOWN_LO, 1, 0));
    send(req(FN_CREATE, 0, 0));
    send(req(FN_INSERT, 1, 7));
    send(req(FN_CLEAR, 0, 0));
    send(req(FN_DESTROY, 0, 0));
    send(req(FN_CLEAR, 0, 0));

    // fill to capacity, then poke the full list at its edges
    send(req(FN_CREATE, 0, 0));
    while (lst_len < CAPACITY) begin
      send(req(FN_INSERT, $urandom_range(1, lst_len + 1), pick_value()));
    end
    send(req(FN_INSERT, CAPACITY + 1, 1));
    send(req(FN_INSERT, 1, 1));
    send(req(FN_INSERT, CAPACITY + 2, 1));
    send(req(FN_GET, CAPACITY, 0));
    repeat (4) send(req(FN_NEXT, $urandom_range(0, 255), pick_value()));
    repeat (4) send(req(FN_PRIOR, $urandom_range(0, 255), pick_value()));
    send(req(FN_DELETE, CAPACITY, 0));
    send(req(FN_DELETE, 1, 0));
    drain_results();

    while (sent < ITEMS) begin
      phase = $urandom_range(0, 9);
      n     = $urandom_range(10, 60);
      repeat (n) begin
        if (phase == 0) send(req(4'($urandom_range(0, 15)), $urandom_range(0, 255), $urandom));
        else if (phase <= 3) send(next_req(75, 10));
        else if (phase <= 5) send(next_req(10, 65));
        else send(next_req(18, 17));
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (CAPACITY + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/slist_pkg.sv
hw/rtl/slist_ctrl.sv
hw/rtl/slist_dp.sv
hw/rtl/sequential_list_engine.sv
sim/slist_checker.sv
sim/tb_sequential_list_engine.sv
